// ===== hw/rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types for the first-fit allocator: the command bundle that the
// controller drives and the status bundle that the datapath returns.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic clear_step;    // write zero at the walk pointer and advance
    logic load;          // capture an accepted request
    logic scan_init;     // restart the first-fit search at cell 0
    logic scan_step;     // one cell read and one cell evaluated
    logic fill_step;     // write the owner at the walk pointer and advance
    logic free_init;     // point the walk at the start of the block to free
    logic free_step;     // clear one cell of the block being freed
    logic alloc_commit;  // update the count and result after a good allocation
    logic free_commit;   // update the count and result after a free
    logic fail_commit;   // post a failed allocation result
  } cmd_t;

  typedef struct packed {
    logic clear_last;  // the clearing pass is at its last cell
    logic op_free;     // the held request is a free
    logic reject;      // the held allocation fails its up-front checks
    logic found;       // the search has just found a long enough run
    logic exhausted;   // the search ran past the last cell
    logic fill_last;   // the fill is at its last cell
    logic free_done;   // nothing more to clear for the free
  } status_t;

endpackage

// ===== hw/rtl/first_fit_memory_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_memory_allocator
// First-fit contiguous allocator over a store of owner-tagged cells.
// ----------------------------------------------------------------------------
// The block takes one request at a time and answers each with one result
// beat. After reset it runs a clearing pass over every cell of the cell
// memory, during which in_ready_o stays low. An allocation that fails its
// up-front checks goes from the check state straight to its result;
// otherwise the search reads the single-port cell memory one cell per cycle
// from cell 0 and stops at the first run long enough, then writes the block
// one cell per cycle. A free clears size cells from start_cell up, but none
// past the last cell of the memory. The memory port is shared by the search
// and the writes.
module first_fit_memory_allocator #(
  parameter int CELLS      = 128,
  parameter int OWNER_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] size_i,
  input  logic [7:0] owner_id_i,
  input  logic [6:0] start_cell_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       ok_o,
  output logic [6:0] out_start_o,
  output logic [6:0] out_end_o,
  output logic [7:0] used_total_o
);

  ffa_pkg::cmd_t    cmd;
  ffa_pkg::status_t status;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ffa_dpath #(
    .CELLS      (CELLS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .opcode_i     (opcode_i),
    .size_i       (size_i),
    .owner_id_i   (owner_id_i),
    .start_cell_i (start_cell_i),
    .ok_o         (ok_o),
    .out_start_o  (out_start_o),
    .out_end_o    (out_end_o),
    .used_total_o (used_total_o)
  );

endmodule

// ===== hw/rtl/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for the allocator: clearing pass, request check, first-fit
// search, fill, free walk and result handshake.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ffa_pkg::status_t status_i,
  output ffa_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FILL,
    ST_FREE,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.op_free) begin
          cmd_o.free_init = 1'b1;
          state_d         = ST_FREE;
        end else if (status_i.reject) begin
          cmd_o.fail_commit = 1'b1;
          state_d           = ST_RESP;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.exhausted) begin
          cmd_o.fail_commit = 1'b1;
          state_d           = ST_RESP;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (status_i.found) begin
            state_d = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          cmd_o.alloc_commit = 1'b1;
          state_d            = ST_RESP;
        end
      end
      ST_FREE: begin
        if (status_i.free_done) begin
          cmd_o.free_commit = 1'b1;
          state_d           = ST_RESP;
        end else begin
          cmd_o.free_step = 1'b1;
        end
      end
      ST_RESP: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RESP);

endmodule

// ===== hw/rtl/ffa_dpath.sv =====
// ----------------------------------------------------------------------------
// ffa_dpath
// Cell owner memory, walk pointer, run tracker, used-cell count and the
// result register of the allocator.
// ----------------------------------------------------------------------------
module ffa_dpath #(
  parameter int CELLS      = 128,
  parameter int OWNER_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ffa_pkg::cmd_t    cmd_i,
  output ffa_pkg::status_t status_o,
  input  logic             opcode_i,
  input  logic [7:0]       size_i,
  input  logic [7:0]       owner_id_i,
  input  logic [6:0]       start_cell_i,
  output logic             ok_o,
  output logic [6:0]       out_start_o,
  output logic [6:0]       out_end_o,
  output logic [7:0]       used_total_o
);

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  // The walk pointer must hold CELLS itself and any 7-bit start cell.
  localparam int CW = (AW >= 7) ? AW + 1 : 8;
  localparam int UW = $clog2(CELLS + 1);

  logic [OWNER_BITS-1:0] mem [CELLS];

  logic                  op_q;
  logic [7:0]            size_q;
  logic [OWNER_BITS-1:0] owner_q;
  logic [6:0]            start_q;
  logic [CW-1:0]         addr_q, addr_d;
  logic [7:0]            rem_q, rem_d;
  logic [7:0]            run_q, run_d;
  logic [AW-1:0]         run_start_q, run_start_d;
  logic [AW-1:0]         eval_addr_q, eval_addr_d;
  logic                  eval_vld_q, eval_vld_d;
  logic [AW-1:0]         blk_start_q, blk_start_d;
  logic [OWNER_BITS-1:0] rd_q;
  logic [UW-1:0]         used_q, used_d;
  logic                  ok_q;
  logic [6:0]            res_start_q, res_end_q;

  logic                  we;
  logic [OWNER_BITS-1:0] wdata;
  logic                  rd_en;
  logic                  addr_in_range;
  logic                  found;
  logic [AW-1:0]         found_start;
  logic [CW-1:0]         blk_end;

  assign addr_in_range = (int'(addr_q) < CELLS);

  // A free cell that brings the current run up to the requested length.
  assign found       = eval_vld_q && (rd_q == '0) && ((run_q + 8'd1) >= size_q);
  assign found_start = (run_q == 8'd0) ? eval_addr_q : run_start_q;
  assign blk_end     = CW'(blk_start_q) + CW'(size_q) - CW'(1);

  always_comb begin
    addr_d      = addr_q;
    rem_d       = rem_q;
    run_d       = run_q;
    run_start_d = run_start_q;
    eval_addr_d = eval_addr_q;
    eval_vld_d  = eval_vld_q;
    blk_start_d = blk_start_q;
    used_d      = used_q;
    we          = 1'b0;
    wdata       = '0;
    rd_en       = 1'b0;

    if (cmd_i.clear_step) begin
      we     = 1'b1;
      addr_d = addr_q + CW'(1);
    end

    if (cmd_i.scan_init) begin
      addr_d     = '0;
      run_d      = '0;
      eval_vld_d = 1'b0;
    end

    if (cmd_i.scan_step) begin
      // Issue the read of the next cell while the previous one is judged.
      if (addr_in_range) begin
        rd_en       = 1'b1;
        addr_d      = addr_q + CW'(1);
        eval_vld_d  = 1'b1;
        eval_addr_d = addr_q[AW-1:0];
      end else begin
        eval_vld_d = 1'b0;
      end
      if (eval_vld_q) begin
        if (rd_q == '0) begin
          if (run_q == 8'd0) begin
            run_start_d = eval_addr_q;
          end
          run_d = run_q + 8'd1;
        end else begin
          run_d = '0;
        end
      end
      if (found) begin
        blk_start_d = found_start;
        addr_d      = CW'(found_start);
        rem_d       = size_q;
        eval_vld_d  = 1'b0;
      end
    end

    if (cmd_i.fill_step) begin
      we     = 1'b1;
      wdata  = owner_q;
      addr_d = addr_q + CW'(1);
      rem_d  = rem_q - 8'd1;
    end

    if (cmd_i.free_init) begin
      addr_d = CW'(start_q);
      rem_d  = size_q;
    end

    if (cmd_i.free_step) begin
      we     = 1'b1;
      addr_d = addr_q + CW'(1);
      rem_d  = rem_q - 8'd1;
    end

    if (cmd_i.alloc_commit) begin
      used_d = used_q + UW'(size_q);
    end

    if (cmd_i.free_commit) begin
      used_d = (int'(used_q) > int'(size_q)) ? used_q - UW'(size_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      rem_q      <= '0;
      run_q      <= '0;
      eval_vld_q <= 1'b0;
      used_q     <= '0;
    end else begin
      addr_q     <= addr_d;
      rem_q      <= rem_d;
      run_q      <= run_d;
      eval_vld_q <= eval_vld_d;
      used_q     <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_start_q <= run_start_d;
    eval_addr_q <= eval_addr_d;
    blk_start_q <= blk_start_d;
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      size_q  <= size_i;
      owner_q <= OWNER_BITS'(owner_id_i);
      start_q <= start_cell_i;
    end
    if (cmd_i.alloc_commit) begin
      ok_q        <= 1'b1;
      res_start_q <= 7'(blk_start_q);
      res_end_q   <= 7'(blk_end);
    end else if (cmd_i.free_commit || cmd_i.fail_commit) begin
      ok_q        <= cmd_i.free_commit;
      res_start_q <= '0;
      res_end_q   <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr_q[AW-1:0]] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[addr_q[AW-1:0]];
    end
  end

  assign status_o.clear_last = (int'(addr_q) == CELLS - 1);
  assign status_o.op_free    = (op_q == ffa_pkg::OP_FREE);
  assign status_o.reject     = (size_q == 8'd0) || (int'(size_q) > CELLS) ||
                               (owner_q == '0) ||
                               (int'(used_q) + int'(size_q) > CELLS);
  assign status_o.found      = found;
  assign status_o.exhausted  = !eval_vld_q && !addr_in_range;
  assign status_o.fill_last  = (rem_q == 8'd1);
  assign status_o.free_done  = (rem_q == 8'd0) || !addr_in_range;

  assign ok_o         = ok_q;
  assign out_start_o  = res_start_q;
  assign out_end_o    = res_end_q;
  assign used_total_o = 8'(used_q);

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit allocator. Requests go out through a
// random-paced driver, each accepted beat updates a shadow cell map that
// predicts the result, and a monitor with random back-pressure compares every
// result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS      = 128;
  localparam int NUM_RANDOM = 1530;
  localparam int TAIL_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic       op;
    logic [7:0] size;
    logic [7:0] owner;
    logic [6:0] start;
  } request_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] blk_start;
    logic [6:0] blk_end;
    logic [7:0] used;
  } result_t;

  typedef struct packed {
    logic [CELLS-1:0][7:0] owner;
    logic [7:0]            used;
  } cell_map_t;

  typedef struct packed {
    logic [6:0] start;
    logic [7:0] size;
  } block_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       in_valid   = 1'b0;
  logic       opcode     = ffa_pkg::OP_ALLOC;
  logic [7:0] size       = '0;
  logic [7:0] owner_id   = '0;
  logic [6:0] start_cell = '0;
  logic       out_ready  = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic       ok;
  logic [6:0] out_start;
  logic [6:0] out_end;
  logic [7:0] used_total;

  request_t  request_q[$];
  result_t   expected_result_q[$];
  block_t    live_blocks[$];
  cell_map_t gen_map;
  cell_map_t chk_map;
  request_t  held_req;
  int        items_sent   = 0;
  int        results_seen = 0;
  int        errors       = 0;

  first_fit_memory_allocator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (opcode),
    .size_i       (size),
    .owner_id_i   (owner_id),
    .start_cell_i (start_cell),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .ok_o         (ok),
    .out_start_o  (out_start),
    .out_end_o    (out_end),
    .used_total_o (used_total)
  );

  always #1 clk_i = ~clk_i;

  // Applies one request to a cell map and returns the result it produces.
  function automatic result_t allocate_or_free(inout cell_map_t m, input request_t rq);
    result_t r;
    int      sz;
    int      st;
    int      run;
    int      run_at;
    int      at;
    int      c;
    bit      hit;
    r      = '0;
    sz     = int'(rq.size);
    st     = int'(rq.start);
    run    = 0;
    run_at = 0;
    at     = 0;
    hit    = 1'b0;
    if (rq.op == ffa_pkg::OP_ALLOC) begin
      if (sz != 0 && sz <= CELLS && rq.owner != '0 && int'(m.used) + sz <= CELLS) begin
        for (c = 0; c < CELLS && !hit; c++) begin
          if (m.owner[c] == '0) begin
            if (run == 0) run_at = c;
            run++;
            if (run >= sz) begin
              hit = 1'b1;
              at  = run_at;
            end
          end else begin
            run = 0;
          end
        end
      end
      if (hit) begin
        for (c = at; c < at + sz; c++) m.owner[c] = rq.owner;
        m.used      = m.used + rq.size;
        r.ok        = 1'b1;
        r.blk_start = at[6:0];
        r.blk_end   = 7'(at + sz - 1);
      end
    end else begin
      for (c = st; c < st + sz && c < CELLS; c++) m.owner[c] = '0;
      m.used = (m.used > rq.size) ? m.used - rq.size : '0;
      r.ok   = 1'b1;
    end
    r.used = m.used;
    return r;
  endfunction

  // Queues a request and tracks the blocks it leaves allocated, so that
  // later frees can target real blocks.
  task automatic push_req(input logic op, input int sz, input int own, input int st);
    request_t rq;
    result_t  r;
    block_t   b;
    rq.op    = op;
    rq.size  = sz[7:0];
    rq.owner = own[7:0];
    rq.start = st[6:0];
    r = allocate_or_free(gen_map, rq);
    if (op == ffa_pkg::OP_ALLOC && r.ok) begin
      b.start = r.blk_start;
      b.size  = rq.size;
      live_blocks.push_back(b);
    end
    request_q.push_back(rq);
  endtask

  task automatic push_random_alloc();
    int pick;
    int sz;
    pick = $urandom_range(99);
    if (pick < 85)      sz = $urandom_range(20, 1);
    else if (pick < 95) sz = $urandom_range(64, 21);
    else                sz = $urandom_range(128, 65);
    push_req(ffa_pkg::OP_ALLOC, sz, $urandom_range(255, 1), $urandom_range(127));
  endtask

  // Driver: a new beat is offered only when the line is free or the held
  // beat is accepted at this edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_result_q.push_back(allocate_or_free(chk_map, held_req));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 &&
            ((items_sent >= 700 && items_sent < 900) || $urandom_range(99) >= 31)) begin
          held_req   = request_q[0];
          request_q.delete(0);
          in_valid   <= 1'b1;
          opcode     <= held_req.op;
          size       <= held_req.size;
          owner_id   <= held_req.owner;
          start_cell <= held_req.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result beat and pulls ready at random, outside a window of steady ready.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {ok, out_start, out_end, used_total};
        results_seen++;
        if (expected_result_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result beat: ok=%0d start=%0d end=%0d used=%0d",
                     got.ok, got.blk_start, got.blk_end, got.used);
        end else begin
          want = expected_result_q[0];
          expected_result_q.delete(0);
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("result %0d: expected ok=%0d start=%0d end=%0d used=%0d",
                       results_seen, want.ok, want.blk_start, want.blk_end, want.used);
              $display("result %0d: got      ok=%0d start=%0d end=%0d used=%0d",
                       results_seen, got.ok, got.blk_start, got.blk_end, got.used);
            end
          end
        end
      end
      out_ready <= (results_seen >= 400 && results_seen < 600) || ($urandom_range(99) >= 31);
    end
  end

  initial begin
    int     pick;
    int     idx;
    block_t b;
    gen_map = '0;
    chk_map = '0;

    // Directed part: rejections, a full pool, holes, clipping and saturation.
    push_req(ffa_pkg::OP_ALLOC, 0,   5,   0);
    push_req(ffa_pkg::OP_ALLOC, 129, 5,   0);
    push_req(ffa_pkg::OP_ALLOC, 255, 5,   127);
    push_req(ffa_pkg::OP_ALLOC, 4,   0,   0);
    push_req(ffa_pkg::OP_ALLOC, 128, 255, 0);
    push_req(ffa_pkg::OP_ALLOC, 1,   7,   0);
    push_req(ffa_pkg::OP_FREE,  128, 0,   0);
    push_req(ffa_pkg::OP_ALLOC, 1,   1,   0);
    push_req(ffa_pkg::OP_ALLOC, 3,   2,   0);
    push_req(ffa_pkg::OP_FREE,  1,   0,   0);
    push_req(ffa_pkg::OP_ALLOC, 2,   3,   0);
    push_req(ffa_pkg::OP_ALLOC, 1,   4,   0);
    push_req(ffa_pkg::OP_FREE,  10,  0,   127);
    push_req(ffa_pkg::OP_FREE,  0,   0,   5);
    push_req(ffa_pkg::OP_FREE,  200, 0,   1);
    push_req(ffa_pkg::OP_ALLOC, 128, 128, 0);
    push_req(ffa_pkg::OP_FREE,  255, 0,   64);
    push_req(ffa_pkg::OP_ALLOC, 64,  170, 85);
    push_req(ffa_pkg::OP_ALLOC, 64,  85,  42);
    push_req(ffa_pkg::OP_ALLOC, 10,  9,   0);
    push_req(ffa_pkg::OP_FREE,  255, 0,   0);
    live_blocks.delete();

    // Random part: mostly allocations and frees of real blocks, with some
    // malformed requests and stray frees mixed in.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        push_random_alloc();
      end else if (pick < 85) begin
        if (live_blocks.size() != 0) begin
          idx = $urandom_range(live_blocks.size() - 1);
          b   = live_blocks[idx];
          live_blocks.delete(idx);
          push_req(ffa_pkg::OP_FREE, b.size, $urandom_range(255), b.start);
        end else begin
          push_random_alloc();
        end
      end else if (pick < 90) begin
        case ($urandom_range(2))
          0:       push_req(ffa_pkg::OP_ALLOC, 0, $urandom_range(255), $urandom_range(127));
          1:       push_req(ffa_pkg::OP_ALLOC, $urandom_range(255, 129),
                            $urandom_range(255, 1), $urandom_range(127));
          default: push_req(ffa_pkg::OP_ALLOC, $urandom_range(128, 1), 0,
                            $urandom_range(127));
        endcase
      end else begin
        if ($urandom_range(1) == 0)
          push_req(ffa_pkg::OP_FREE, $urandom_range(255), $urandom_range(255),
                   $urandom_range(127));
        else
          push_req(ffa_pkg::OP_FREE, $urandom_range(8), $urandom_range(255),
                   $urandom_range(127, 120));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_result_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0 && expected_result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== first_fit_memory_allocator.f =====
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_ctrl.sv
hw/rtl/ffa_dpath.sv
hw/rtl/first_fit_memory_allocator.sv
tb/testbench.sv
